// ----- rtl/trilinear_grid_interpolator_defines.svh -----
// Assertion macros used by the checker file.
`ifndef TRILINEAR_GRID_INTERPOLATOR_DEFINES_SVH
`define TRILINEAR_GRID_INTERPOLATOR_DEFINES_SVH

// Implication checked on every edge outside reset.
`define TGI_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked after the delay given by argument n.
`define TGI_ASSERT_DELAYED(label, clk, rst_n, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
    else $error(msg);

// Implication that is also checked while reset is applied.
`define TGI_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tgi_pkg.sv -----
package tgi_pkg;

  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_LOOKUP = 1'b1
  } func_t;

  localparam int COORD_W   = 16;
  localparam int FRAC_W    = 16;
  localparam int ADDR_W    = 16;
  localparam int VALUE_W   = 16;
  localparam int NUM_BANKS = 8;

  typedef logic [FRAC_W-1:0] frac_t;

  typedef struct packed {
    logic       vld;
    logic [2:0] par;
    frac_t      fx;
    frac_t      fy;
    frac_t      fz;
  } ctl_t;

endpackage

// ----- rtl/tgi_addr.sv -----
module tgi_addr #(
  parameter int GRID_POINTS = 33,
  parameter int SAMPLE_BITS = 16,
  parameter int BANK_AW     = 13
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            in_vld,
  input  logic                                            func,
  input  logic [tgi_pkg::ADDR_W-1:0]                      grid_address,
  input  logic signed [tgi_pkg::VALUE_W-1:0]              grid_value,
  input  logic [tgi_pkg::COORD_W-1:0]                     coord_x,
  input  logic [tgi_pkg::COORD_W-1:0]                     coord_y,
  input  logic [tgi_pkg::COORD_W-1:0]                     coord_z,
  output logic [tgi_pkg::NUM_BANKS-1:0][BANK_AW-1:0]      bank_addr,
  output logic [tgi_pkg::NUM_BANKS-1:0]                   bank_we,
  output logic [SAMPLE_BITS-1:0]                          bank_wdata,
  output tgi_pkg::ctl_t                                   ctl
);
  import tgi_pkg::*;

  localparam int IW = $clog2(GRID_POINTS);
  localparam int H  = (GRID_POINTS + 1) / 2;
  localparam int HW = (H > 1) ? $clog2(H) : 1;
  localparam int D1 = GRID_POINTS * GRID_POINTS;
  localparam int CELLS = D1 * GRID_POINTS;
  localparam int S1 = ADDR_W + $clog2(D1);
  localparam int S2 = ADDR_W + $clog2(GRID_POINTS);
  localparam longint M1 = ((longint'(1) << S1) + D1 - 1) / D1;
  localparam longint M2 = ((longint'(1) << S2) + GRID_POINTS - 1) / GRID_POINTS;
  localparam int PW = 48;
  localparam int TW = FRAC_W + IW;

  function automatic logic [TW-1:0] scale(input logic [COORD_W-1:0] c);
    return TW'(c) * TW'(GRID_POINTS - 1);
  endfunction

  function automatic logic [HW-1:0] half(input logic [IW-1:0] i, input logic p,
                                         input logic look);
    logic [IW:0] s;
    s = {1'b0, i} + {{IW{1'b0}}, look & (p ^ i[0])};
    return s[HW:1];
  endfunction

  // Input register.
  logic                    s0_vld_r;
  logic                    s0_func_r;
  logic [ADDR_W-1:0]       s0_addr_r;
  logic [VALUE_W-1:0]      s0_value_r;
  logic [COORD_W-1:0]      s0_cx_r, s0_cy_r, s0_cz_r;

  // Cell location for lookups, quotient estimates for loads.
  logic                    s1_look_r, s1_look_nxt;
  logic                    s1_wr_r, s1_wr_nxt;
  logic [IW-1:0]           s1_ix_r, s1_iy_r, s1_iz_r;
  logic [IW-1:0]           s1_ix_nxt, s1_iy_nxt, s1_iz_nxt;
  frac_t                   s1_fx_r, s1_fy_r, s1_fz_r;
  frac_t                   s1_fx_nxt, s1_fy_nxt, s1_fz_nxt;
  logic [IW-1:0]           s1_qx_r, s1_qx_nxt;
  logic [ADDR_W-1:0]       s1_qxy_r, s1_qxy_nxt;
  logic [ADDR_W-1:0]       s1_addr_r;
  logic [SAMPLE_BITS-1:0]  s1_wdata_r, s1_wdata_nxt;
  logic [TW-1:0]           tx, ty, tz;
  logic [PW-1:0]           pa, pb;
  logic [2*VALUE_W-1:0]    sext;

  // Half indices per axis and parity.
  logic                    s2_look_r, s2_wr_r;
  logic [1:0][HW-1:0]      s2_hx_r, s2_hy_r, s2_hz_r;
  logic [1:0][HW-1:0]      s2_hx_nxt, s2_hy_nxt, s2_hz_nxt;
  logic [2:0]              s2_par_r, s2_par_nxt;
  frac_t                   s2_fx_r, s2_fy_r, s2_fz_r;
  logic [SAMPLE_BITS-1:0]  s2_wdata_r;
  logic [IW-1:0]           ly, lz, ax, ay, az;

  // Bank addresses.
  logic [NUM_BANKS-1:0][BANK_AW-1:0] s3_addr_r, s3_addr_nxt;
  logic [NUM_BANKS-1:0]    s3_we_r, s3_we_nxt;
  logic [SAMPLE_BITS-1:0]  s3_wdata_r;
  ctl_t                    s3_ctl_r, s3_ctl_nxt;

  always_comb begin
    tx = scale(s0_cx_r);
    ty = scale(s0_cy_r);
    tz = scale(s0_cz_r);
    s1_ix_nxt = tx[FRAC_W +: IW];
    s1_iy_nxt = ty[FRAC_W +: IW];
    s1_iz_nxt = tz[FRAC_W +: IW];
    s1_fx_nxt = tx[FRAC_W-1:0];
    s1_fy_nxt = ty[FRAC_W-1:0];
    s1_fz_nxt = tz[FRAC_W-1:0];
    pa = PW'(s0_addr_r) * PW'(M1);
    pb = PW'(s0_addr_r) * PW'(M2);
    s1_qx_nxt  = pa[S1 +: IW];
    s1_qxy_nxt = pb[S2 +: ADDR_W];
    sext = {{VALUE_W{s0_value_r[VALUE_W-1]}}, s0_value_r};
    s1_wdata_nxt = sext[SAMPLE_BITS-1:0];
    s1_look_nxt = s0_vld_r && (s0_func_r == FUNC_LOOKUP);
    s1_wr_nxt = s0_vld_r && (s0_func_r == FUNC_LOAD) && (32'(s0_addr_r) < 32'(CELLS));
  end

  always_comb begin
    ly = IW'(s1_qxy_r - ADDR_W'(s1_qx_r) * ADDR_W'(GRID_POINTS));
    lz = IW'(s1_addr_r - s1_qxy_r * ADDR_W'(GRID_POINTS));
    ax = s1_look_r ? s1_ix_r : s1_qx_r;
    ay = s1_look_r ? s1_iy_r : ly;
    az = s1_look_r ? s1_iz_r : lz;
    for (int p = 0; p < 2; p++) begin
      s2_hx_nxt[p] = half(ax, p[0], s1_look_r);
      s2_hy_nxt[p] = half(ay, p[0], s1_look_r);
      s2_hz_nxt[p] = half(az, p[0], s1_look_r);
    end
    s2_par_nxt = {ax[0], ay[0], az[0]};
  end

  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      s3_addr_nxt[b] = BANK_AW'(32'(s2_hx_r[b[2]]) * 32'(H * H)
                              + 32'(s2_hy_r[b[1]]) * 32'(H)
                              + 32'(s2_hz_r[b[0]]));
      s3_we_nxt[b] = s2_wr_r && (s2_par_r == 3'(b));
    end
    s3_ctl_nxt.vld = s2_look_r;
    s3_ctl_nxt.par = s2_par_r;
    s3_ctl_nxt.fx  = s2_fx_r;
    s3_ctl_nxt.fy  = s2_fy_r;
    s3_ctl_nxt.fz  = s2_fz_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r  <= 1'b0;
      s1_look_r <= 1'b0;
      s1_wr_r   <= 1'b0;
      s2_look_r <= 1'b0;
      s2_wr_r   <= 1'b0;
      s3_we_r   <= '0;
      s3_ctl_r  <= '0;
    end else begin
      s0_vld_r  <= in_vld;
      s1_look_r <= s1_look_nxt;
      s1_wr_r   <= s1_wr_nxt;
      s2_look_r <= s1_look_r;
      s2_wr_r   <= s1_wr_r;
      s3_we_r   <= s3_we_nxt;
      s3_ctl_r  <= s3_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s0_func_r  <= func;
    s0_addr_r  <= grid_address;
    s0_value_r <= grid_value;
    s0_cx_r    <= coord_x;
    s0_cy_r    <= coord_y;
    s0_cz_r    <= coord_z;
    s1_ix_r    <= s1_ix_nxt;
    s1_iy_r    <= s1_iy_nxt;
    s1_iz_r    <= s1_iz_nxt;
    s1_fx_r    <= s1_fx_nxt;
    s1_fy_r    <= s1_fy_nxt;
    s1_fz_r    <= s1_fz_nxt;
    s1_qx_r    <= s1_qx_nxt;
    s1_qxy_r   <= s1_qxy_nxt;
    s1_addr_r  <= s0_addr_r;
    s1_wdata_r <= s1_wdata_nxt;
    s2_hx_r    <= s2_hx_nxt;
    s2_hy_r    <= s2_hy_nxt;
    s2_hz_r    <= s2_hz_nxt;
    s2_par_r   <= s2_par_nxt;
    s2_fx_r    <= s1_fx_r;
    s2_fy_r    <= s1_fy_r;
    s2_fz_r    <= s1_fz_r;
    s2_wdata_r <= s1_wdata_r;
    s3_addr_r  <= s3_addr_nxt;
    s3_wdata_r <= s2_wdata_r;
  end

  assign bank_addr  = s3_addr_r;
  assign bank_we    = s3_we_r;
  assign bank_wdata = s3_wdata_r;
  assign ctl        = s3_ctl_r;

endmodule

// ----- rtl/tgi_bank.sv -----
module tgi_bank #(
  parameter int DEPTH = 4913,
  parameter int AW    = 13,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/tgi_blend.sv -----
module tgi_blend #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  tgi_pkg::ctl_t                                      ctl,
  input  logic [tgi_pkg::NUM_BANKS-1:0][SAMPLE_BITS-1:0]     bank_data,
  output logic                                               out_valid,
  output logic signed [tgi_pkg::VALUE_W-1:0]                 out_value
);
  import tgi_pkg::*;

  localparam int SW = 2 * VALUE_W + 1;
  localparam logic signed [SW-1:0] SAT_HI = SW'(32767);
  localparam logic signed [SW-1:0] SAT_LO = -SW'(32768);

  function automatic logic [SAMPLE_BITS-1:0] lerp(input logic [SAMPLE_BITS-1:0] a,
                                                  input logic [SAMPLE_BITS-1:0] b,
                                                  input frac_t f);
    logic signed [SAMPLE_BITS:0]          d;
    logic signed [SAMPLE_BITS+FRAC_W+1:0] acc;
    d = $signed({b[SAMPLE_BITS-1], b}) - $signed({a[SAMPLE_BITS-1], a});
    acc = $signed({{2{a[SAMPLE_BITS-1]}}, a, {FRAC_W{1'b0}}})
        + d * $signed({1'b0, f})
        + $signed({{(SAMPLE_BITS+2){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}});
    return acc[SAMPLE_BITS+FRAC_W-1:FRAC_W];
  endfunction

  logic                         s5_vld_r;
  logic [3:0][SAMPLE_BITS-1:0]  s5_c_r, s5_c_nxt;
  frac_t                        s5_fy_r, s5_fz_r;
  logic                         s6_vld_r;
  logic [1:0][SAMPLE_BITS-1:0]  s6_c_r, s6_c_nxt;
  frac_t                        s6_fz_r;
  logic                         out_valid_r;
  logic [VALUE_W-1:0]           out_value_r, out_value_nxt;
  logic [SAMPLE_BITS-1:0]       r;
  logic signed [SW-1:0]         rw;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      s5_c_nxt[k] = lerp(bank_data[{1'b0, 2'(k)} ^ ctl.par],
                         bank_data[{1'b1, 2'(k)} ^ ctl.par], ctl.fx);
    end
    for (int k = 0; k < 2; k++) begin
      s6_c_nxt[k] = lerp(s5_c_r[{1'b0, k[0]}], s5_c_r[{1'b1, k[0]}], s5_fy_r);
    end
    r  = lerp(s6_c_r[0], s6_c_r[1], s6_fz_r);
    rw = $signed({{(SW-SAMPLE_BITS){r[SAMPLE_BITS-1]}}, r});
    if (rw > SAT_HI) begin
      out_value_nxt = SAT_HI[VALUE_W-1:0];
    end else if (rw < SAT_LO) begin
      out_value_nxt = SAT_LO[VALUE_W-1:0];
    end else begin
      out_value_nxt = rw[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r    <= 1'b0;
      s6_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s5_vld_r    <= ctl.vld;
      s6_vld_r    <= s5_vld_r;
      out_valid_r <= s6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s5_c_r      <= s5_c_nxt;
    s5_fy_r     <= ctl.fy;
    s5_fz_r     <= ctl.fz;
    s6_c_r      <= s6_c_nxt;
    s6_fz_r     <= s5_fz_r;
    out_value_r <= out_value_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_value = $signed(out_value_r);

endmodule

// ----- rtl/trilinear_grid_interpolator.sv -----
// Channel   Direction  Handshake              Payload
// input     in         start high, busy low   in_func, in_grid_address, in_grid_value,
//                                             in_coord_x, in_coord_y, in_coord_z
// result    out        out_valid, one cycle   out_blended_value
//
// One transaction is taken every clock cycle while busy is low; the pipeline never stalls.
// A lookup's result comes through stages s0 to s6 and the output register to out_valid.
// A load inside the grid is written after stages s0 to s3; any later lookup sees it.
// The grid is split into eight parity banks so all eight corners are read in the same cycle.
// Reset clears the pipeline valid bits; busy is high in reset and falls at the first edge after.
// Results cannot be held off by the receiver, so nothing ever back-pressures the input.
module trilinear_grid_interpolator #(
  parameter int GRID_POINTS = 33,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_func,
  input  logic [tgi_pkg::ADDR_W-1:0]            in_grid_address,
  input  logic signed [tgi_pkg::VALUE_W-1:0]    in_grid_value,
  input  logic [tgi_pkg::COORD_W-1:0]           in_coord_x,
  input  logic [tgi_pkg::COORD_W-1:0]           in_coord_y,
  input  logic [tgi_pkg::COORD_W-1:0]           in_coord_z,
  output logic                                  out_valid,
  output logic signed [tgi_pkg::VALUE_W-1:0]    out_blended_value
);
  import tgi_pkg::*;

  localparam int H       = (GRID_POINTS + 1) / 2;
  localparam int BANK_D  = H * H * H;
  localparam int BANK_AW = (BANK_D > 1) ? $clog2(BANK_D) : 1;

  logic                                  busy_r;
  logic                                  accept;
  logic [NUM_BANKS-1:0][BANK_AW-1:0]     bank_addr;
  logic [NUM_BANKS-1:0]                  bank_we;
  logic [SAMPLE_BITS-1:0]                bank_wdata;
  logic [NUM_BANKS-1:0][SAMPLE_BITS-1:0] bank_data;
  ctl_t                                  ctl_s3;
  ctl_t                                  ctl_s4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      ctl_s4_r <= '0;
    end else begin
      busy_r   <= 1'b0;
      ctl_s4_r <= ctl_s3;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  tgi_addr #(
    .GRID_POINTS (GRID_POINTS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .BANK_AW     (BANK_AW)
  ) u_addr (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_vld       (accept),
    .func         (in_func),
    .grid_address (in_grid_address),
    .grid_value   (in_grid_value),
    .coord_x      (in_coord_x),
    .coord_y      (in_coord_y),
    .coord_z      (in_coord_z),
    .bank_addr    (bank_addr),
    .bank_we      (bank_we),
    .bank_wdata   (bank_wdata),
    .ctl          (ctl_s3)
  );

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    tgi_bank #(
      .DEPTH (BANK_D),
      .AW    (BANK_AW),
      .DW    (SAMPLE_BITS)
    ) u_bank (
      .clk   (clk),
      .we    (bank_we[b]),
      .addr  (bank_addr[b]),
      .wdata (bank_wdata),
      .rdata (bank_data[b])
    );
  end

  tgi_blend #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl_s4_r),
    .bank_data (bank_data),
    .out_valid (out_valid),
    .out_value (out_blended_value)
  );

endmodule

// ----- rtl/tgi_checker.sv -----
`include "trilinear_grid_interpolator_defines.svh"

module tgi_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_func,
  input logic out_valid
);
  import tgi_pkg::*;

  localparam int LATENCY = 8;

  `TGI_ASSERT_DELAYED(a_lookup_result, clk, rst_n, start && !busy && in_func == FUNC_LOOKUP, LATENCY, out_valid, "lookup transaction produced no result")
  `TGI_ASSERT_DELAYED(a_load_silent, clk, rst_n, start && !busy && in_func == FUNC_LOAD, LATENCY, !out_valid, "load transaction produced a result")
  `TGI_ASSERT_ALWAYS(a_busy_low, clk, rst_n && $past(rst_n), !busy, "busy raised outside reset")
  `TGI_ASSERT_ALWAYS(a_reset_quiet, clk, !$past(rst_n), !out_valid, "result strobe right after reset")

endmodule

bind trilinear_grid_interpolator tgi_checker u_checker (.*);

// ----- bench/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tgi_pkg::*;

  localparam int GRID_N      = 33;
  localparam int GRID_CELLS  = GRID_N * GRID_N * GRID_N;
  localparam int CELL_SPAN   = 65536 / (GRID_N - 1);
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_LIMIT = 64;
  localparam int SETTLE      = 16;

  typedef struct packed {
    func_t              op;
    logic [15:0]        addr;
    logic signed [15:0] value;
    logic [15:0]        cx;
    logic [15:0]        cy;
    logic [15:0]        cz;
    bit                 typed;
    logic signed [15:0] want;
  } step_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      in_func = 1'b0;
  logic [ADDR_W-1:0]         in_grid_address = '0;
  logic signed [VALUE_W-1:0] in_grid_value = '0;
  logic [COORD_W-1:0]        in_coord_x = '0;
  logic [COORD_W-1:0]        in_coord_y = '0;
  logic [COORD_W-1:0]        in_coord_z = '0;
  logic                      out_valid;
  logic signed [VALUE_W-1:0] out_blended_value;

  logic signed [15:0] sample_copy [GRID_CELLS];
  bit                 loaded [GRID_CELLS];
  logic signed [15:0] pending_values [$];
  int unsigned        hot_cells [$];
  int                 idle_pct = 0;
  int                 random_items = 0;
  int                 mismatch_count = 0;
  int                 cycle_count = 0;

  step_t directed_steps [0:24] = '{
    '{FUNC_LOAD,   16'd0,     16'sd32767,  16'h0000, 16'h0000, 16'h0000, 1'b0, 16'sd0},
    '{FUNC_LOAD,   16'd1,     -16'sd32768, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'sd0},
    '{FUNC_LOAD,   16'd33,    16'sd100,    16'h0000, 16'h0000, 16'h0000, 1'b0, 16'sd0},
    '{FUNC_LOAD,   16'd34,    -16'sd100,   16'h0000, 16'h0000, 16'h0000, 1'b0, 16'sd0},
    '{FUNC_LOAD,   16'd1089,  16'sd0,      16'h0000, 16'h0000, 16'h0000, 1'b0, 16'sd0},
    '{FUNC_LOAD,   16'd1090,  -16'sd1,     16'h0000, 16'h0000, 16'h0000, 1'b0, 16'sd0},
    '{FUNC_LOAD,   16'd1122,  16'sd12345,  16'h0000, 16'h0000, 16'h0000, 1'b0, 16'sd0},
    '{FUNC_LOAD,   16'd1123,  -16'sd12345, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'sd0},
    '{FUNC_LOOKUP, 16'd0,     16'sd0,      16'h0000, 16'h0000, 16'h0000, 1'b1, 16'sd32767},
    '{FUNC_LOOKUP, 16'd0,     16'sd0,      16'h0400, 16'h0400, 16'h0400, 1'b0, 16'sd0},
    '{FUNC_LOOKUP, 16'd0,     16'sd0,      16'h07FF, 16'h0000, 16'h0001, 1'b0, 16'sd0},
    '{FUNC_LOAD,   16'd35937, 16'sd1111,   16'h0000, 16'h0000, 16'h0000, 1'b0, 16'sd0},
    '{FUNC_LOAD,   16'd65535, -16'sd1,     16'h0000, 16'h0000, 16'h0000, 1'b0, 16'sd0},
    '{FUNC_LOAD,   16'd34813, -16'sd32768, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'sd0},
    '{FUNC_LOAD,   16'd34814, 16'sd32767,  16'h0000, 16'h0000, 16'h0000, 1'b0, 16'sd0},
    '{FUNC_LOAD,   16'd34846, -16'sd32768, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'sd0},
    '{FUNC_LOAD,   16'd34847, 16'sd32767,  16'h0000, 16'h0000, 16'h0000, 1'b0, 16'sd0},
    '{FUNC_LOAD,   16'd35902, -16'sd32768, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'sd0},
    '{FUNC_LOAD,   16'd35903, 16'sd32767,  16'h0000, 16'h0000, 16'h0000, 1'b0, 16'sd0},
    '{FUNC_LOAD,   16'd35935, -16'sd32768, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'sd0},
    '{FUNC_LOAD,   16'd35936, 16'sd32767,  16'h0000, 16'h0000, 16'h0000, 1'b0, 16'sd0},
    '{FUNC_LOOKUP, 16'd0,     16'sd0,      16'hF800, 16'hF800, 16'hF800, 1'b1, -16'sd32768},
    '{FUNC_LOOKUP, 16'd0,     16'sd0,      16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 16'sd0},
    '{FUNC_LOAD,   16'd0,     -16'sd7,     16'h0000, 16'h0000, 16'h0000, 1'b0, 16'sd0},
    '{FUNC_LOOKUP, 16'd0,     16'sd0,      16'h0000, 16'h0000, 16'h0000, 1'b1, -16'sd7}
  };

  trilinear_grid_interpolator #(
    .GRID_POINTS(GRID_N),
    .SAMPLE_BITS(16)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_grid_address  (in_grid_address),
    .in_grid_value    (in_grid_value),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .in_coord_z       (in_coord_z),
    .out_valid        (out_valid),
    .out_blended_value(out_blended_value)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned grid_index(int unsigned x, int unsigned y, int unsigned z);
    return (x * GRID_N + y) * GRID_N + z;
  endfunction

  function automatic void cell_of(input logic [15:0] c, output int unsigned idx,
                                  output int unsigned frac);
    int unsigned t;
    t = c * (GRID_N - 1);
    idx = t >> 16;
    frac = t & 32'hFFFF;
    if (idx > GRID_N - 2) begin
      idx = GRID_N - 2;
      frac = 65536;
    end
  endfunction

  function automatic longint blend_step(longint a, longint b, longint f);
    longint acc;
    acc = a * 65536 + (b - a) * f + 32768;
    return acc >>> 16;
  endfunction

  function automatic longint sample_at(int unsigned x, int unsigned y, int unsigned z);
    return longint'(sample_copy[grid_index(x, y, z)]);
  endfunction

  function automatic logic signed [15:0] blend_point(logic [15:0] cx, logic [15:0] cy,
                                                     logic [15:0] cz);
    int unsigned ix, iy, iz, fx, fy, fz;
    longint c00, c01, c10, c11, c0, c1, r;
    cell_of(cx, ix, fx);
    cell_of(cy, iy, fy);
    cell_of(cz, iz, fz);
    c00 = blend_step(sample_at(ix, iy, iz), sample_at(ix + 1, iy, iz), fx);
    c01 = blend_step(sample_at(ix, iy, iz + 1), sample_at(ix + 1, iy, iz + 1), fx);
    c10 = blend_step(sample_at(ix, iy + 1, iz), sample_at(ix + 1, iy + 1, iz), fx);
    c11 = blend_step(sample_at(ix, iy + 1, iz + 1), sample_at(ix + 1, iy + 1, iz + 1), fx);
    c0 = blend_step(c00, c10, fy);
    c1 = blend_step(c01, c11, fy);
    r = blend_step(c0, c1, fz);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'sd32767;
      1: return -16'sd32768;
      2: return 16'sd0;
      3: return -16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_coord();
    int unsigned span_idx;
    span_idx = $urandom_range(GRID_N - 2);
    case ($urandom_range(4))
      0: return 16'(span_idx * CELL_SPAN);
      1: return 16'(span_idx * CELL_SPAN + CELL_SPAN - 1);
      2: return 16'(span_idx * CELL_SPAN + CELL_SPAN / 2);
      3: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic idle_cycle();
    @(negedge clk);
    start           <= 1'b0;
    in_func         <= 1'($urandom);
    in_grid_address <= 16'($urandom);
    in_grid_value   <= 16'($urandom);
    in_coord_x      <= 16'($urandom);
    in_coord_y      <= 16'($urandom);
    in_coord_z      <= 16'($urandom);
  endtask

  task automatic issue_transaction(func_t op, logic [15:0] addr, logic signed [15:0] value,
                                   logic [15:0] cx, logic [15:0] cy, logic [15:0] cz,
                                   bit typed, logic signed [15:0] want);
    while ($urandom_range(99) < idle_pct) idle_cycle();
    @(negedge clk);
    start           <= 1'b1;
    in_func         <= op;
    in_grid_address <= addr;
    in_grid_value   <= value;
    in_coord_x      <= cx;
    in_coord_y      <= cy;
    in_coord_z      <= cz;
    do @(posedge clk); while (busy !== 1'b0);
    if (op == FUNC_LOAD) begin
      if (addr < GRID_CELLS) begin
        sample_copy[addr] = value;
        loaded[addr] = 1'b1;
        random_items++;
      end
    end else begin
      pending_values.push_back(typed ? want : blend_point(cx, cy, cz));
      random_items++;
    end
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    while (pending_values.size() != 0 && waited < DRAIN_LIMIT) begin
      idle_cycle();
      waited++;
    end
  endtask

  // A lookup is preceded by loads of any corner not yet written, and some
  // corners are rewritten right before it to hit the write-to-read path.
  task automatic lookup_sequence();
    logic [15:0] cx, cy, cz;
    int unsigned ix, iy, iz, fdummy, a, hot;
    if (hot_cells.size() != 0 && $urandom_range(1)) begin
      hot = hot_cells[$urandom_range(hot_cells.size() - 1)];
      cx = 16'(((hot >> 10) & 31) * CELL_SPAN + $urandom_range(CELL_SPAN - 1));
      cy = 16'(((hot >> 5) & 31) * CELL_SPAN + $urandom_range(CELL_SPAN - 1));
      cz = 16'((hot & 31) * CELL_SPAN + $urandom_range(CELL_SPAN - 1));
    end else begin
      cx = pick_coord();
      cy = pick_coord();
      cz = pick_coord();
    end
    cell_of(cx, ix, fdummy);
    cell_of(cy, iy, fdummy);
    cell_of(cz, iz, fdummy);
    hot_cells.push_back((ix << 10) | (iy << 5) | iz);
    if (hot_cells.size() > 32) void'(hot_cells.pop_front());
    for (int d = 0; d < 8; d++) begin
      a = grid_index(ix + d[2], iy + d[1], iz + d[0]);
      if (!loaded[a] || $urandom_range(3) == 0)
        issue_transaction(FUNC_LOAD, 16'(a), pick_sample(),
                          16'($urandom), 16'($urandom), 16'($urandom), 1'b0, '0);
    end
    issue_transaction(FUNC_LOOKUP, 16'($urandom), 16'($urandom), cx, cy, cz, 1'b0, '0);
  endtask

  task automatic random_phase(int target);
    int pick;
    while (random_items < target) begin
      pick = $urandom_range(99);
      if (pick < 70)
        lookup_sequence();
      else if (pick < 92)
        issue_transaction(FUNC_LOAD, 16'($urandom_range(GRID_CELLS - 1)), pick_sample(),
                          16'($urandom), 16'($urandom), 16'($urandom), 1'b0, '0);
      else
        issue_transaction(FUNC_LOAD, 16'($urandom_range(65535, GRID_CELLS)), 16'($urandom),
                          16'($urandom), 16'($urandom), 16'($urandom), 1'b0, '0);
    end
    drain();
  endtask

  always @(posedge clk) begin
    logic signed [15:0] want;
    if (out_valid === 1'b1) begin
      if (pending_values.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $realtime,
                 out_blended_value);
        mismatch_count++;
      end else begin
        want = pending_values.pop_front();
        if (out_blended_value !== want) begin
          $display("%0t: blended_value mismatch, expected %0d, actual %0d", $realtime,
                   want, out_blended_value);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $realtime,
               pending_values.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (directed_steps[i])
      issue_transaction(directed_steps[i].op, directed_steps[i].addr, directed_steps[i].value,
                        directed_steps[i].cx, directed_steps[i].cy, directed_steps[i].cz,
                        directed_steps[i].typed, directed_steps[i].want);
    drain();
    random_items = 0;
    idle_pct = 31;
    random_phase(250);
    idle_pct = 61;
    random_phase(500);
    idle_pct = 0;
    random_phase(750);
    repeat (SETTLE) idle_cycle();
    if (pending_values.size() != 0) begin
      $display("%0t: %0d expected results never arrived, next expected %0d", $realtime,
               pending_values.size(), pending_values[0]);
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/tgi_pkg.sv
rtl/tgi_addr.sv
rtl/tgi_bank.sv
rtl/tgi_blend.sv
rtl/trilinear_grid_interpolator.sv
rtl/tgi_checker.sv
bench/testbench.sv
